// ----- rtl/slpl_pkg.sv -----
// ----------------------------------------------------------------------------
// slpl_pkg
// Shared constants, register codes and types for the stereo peak limiter.
// ----------------------------------------------------------------------------
package slpl_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int CEIL_W           = 23;
   localparam int COEF_W           = 16;
   localparam int GAIN_W           = 17;
   localparam int GAIN_FRAC        = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 23;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
   localparam logic [CEIL_W-1:0] CEIL_RST = 23'd1048576;
   localparam logic [COEF_W-1:0] COEF_RST = 16'd66;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CEILING = 2'd0,
      CSR_RELEASE = 2'd1,
      CSR_LINKED  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CEIL_W-1:0] ceiling;
      logic [COEF_W-1:0] release_coef;
      logic              stereo_linked;
   } cfg_type;

endpackage

// ----- rtl/slpl_fifo.sv -----
// ----------------------------------------------------------------------------
// slpl_fifo
// Short register queue between the classifier and the gain engine.
// ----------------------------------------------------------------------------
module slpl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = slpl_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

// ----- rtl/slpl_front.sv -----
// ----------------------------------------------------------------------------
// slpl_front
// Takes sample pairs, finds the peak and flags it against the ceiling.
// ----------------------------------------------------------------------------
module slpl_front #(
   parameter int SAMPLE_WIDTH = slpl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [SAMPLE_WIDTH-1:0]     req_in_left,
   input  logic [SAMPLE_WIDTH-1:0]     req_in_right,
   input  slpl_pkg::cfg_type           cfg,
   input  logic                        queue_full,
   output logic                        push,
   output logic [3*SAMPLE_WIDTH:0]     push_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int MAG_W = (SW > slpl_pkg::CEIL_W) ? SW : slpl_pkg::CEIL_W;

   logic [SW-1:0]    mag_left, mag_right, peak;
   logic [MAG_W-1:0] peak_ext, ceil_ext;
   logic             over;

   // most negative sample maps to 2^(SW-1), which still fits unsigned
   assign mag_left  = req_in_left[SW-1]  ? (~req_in_left + 1'b1)  : req_in_left;
   assign mag_right = req_in_right[SW-1] ? (~req_in_right + 1'b1) : req_in_right;

   assign peak = (cfg.stereo_linked && (mag_right > mag_left)) ? mag_right : mag_left;

   assign peak_ext = MAG_W'(peak);
   assign ceil_ext = MAG_W'(cfg.ceiling);
   assign over     = peak_ext > ceil_ext;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign push_data = {over, peak, req_in_right, req_in_left};

endmodule

// ----- rtl/slpl_back.sv -----
// ----------------------------------------------------------------------------
// slpl_back
// Gain engine: serial divide for the target, attack/release update,
// shared multiplier for release and both channel products, output register.
// ----------------------------------------------------------------------------
module slpl_back #(
   parameter int SAMPLE_WIDTH = slpl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  slpl_pkg::cfg_type       cfg,
   input  logic                    pop_valid,
   input  logic [3*SAMPLE_WIDTH:0] pop_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_left,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_right
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int GW     = slpl_pkg::GAIN_W;
   localparam int CW     = slpl_pkg::COEF_W;
   localparam int FRAC   = slpl_pkg::GAIN_FRAC;
   localparam int MAG_W  = (SW > slpl_pkg::CEIL_W) ? SW : slpl_pkg::CEIL_W;
   localparam int REM_W  = MAG_W + 1;
   localparam int MA     = SW + 2;
   localparam int MB     = GW + 1;
   localparam int PW     = MA + MB;
   localparam int QW     = PW - FRAC;
   localparam int CNT_W  = $clog2(FRAC);
   localparam int RP_W   = GW + CW;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_REL,
      ST_ADD,
      ST_MUL_L,
      ST_SAT_L,
      ST_MUL_R,
      ST_SAT_R,
      ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [GW-1:0]    gain_ff, gain_in;
   logic [GW-1:0]    target_ff, target_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]    left_ff, left_in;
   logic [SW-1:0]    right_ff, right_in;
   logic [SW-1:0]    peak_ff, peak_in;
   logic [SW-1:0]    res_l_ff, res_l_in;
   logic [SW-1:0]    res_r_ff, res_r_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_left_ff, rsp_left_in;
   logic [SW-1:0]    rsp_right_ff, rsp_right_in;

   logic [REM_W-1:0] rem_shift, peak_ext, rem_sub;
   logic             rem_ge;
   logic [GW-1:0]    diff;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic [RP_W+1:0]  rel_sum;
   logic [GW:0]      step;
   logic [GW+1:0]    gain_sum;
   logic [GW-1:0]    gain_rel;
   logic signed [PW-1:0] rnd;
   logic [SW-1:0]    sat_val;
   logic             out_free;

   function automatic logic [SW-1:0] sat_sample(input logic [QW-1:0] q);
      logic [QW-SW:0] top;
      logic [SW-1:0]  r;
      top = q[QW-1:SW-1];
      if ((&top) || !(|top)) begin
         r = q[SW-1:0];
      end else if (q[QW-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   // restoring divide: dividend low bits are all zero, remainder stays below peak
   assign rem_shift = {rem_ff[REM_W-2:0], 1'b0};
   assign peak_ext  = REM_W'(peak_ff);
   assign rem_ge    = rem_shift >= peak_ext;
   assign rem_sub   = rem_shift - peak_ext;

   assign diff     = target_ff - gain_ff;
   assign rel_sum  = (RP_W+2)'(prod_ff[RP_W-1:0]) + (RP_W+2)'(32768);
   assign step     = rel_sum[GW+FRAC:FRAC];
   assign gain_sum = (GW+2)'(gain_ff) + (GW+2)'(step);
   assign gain_rel = (gain_sum > (GW+2)'(slpl_pkg::GAIN_ONE)) ?
                     slpl_pkg::GAIN_ONE : gain_sum[GW-1:0];

   // round half up, then arithmetic shift is the floor
   assign rnd     = prod_ff + $signed({{(PW-FRAC){1'b0}}, 16'h8000});
   assign sat_val = sat_sample(rnd[PW-1:FRAC]);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;

   always_comb begin
      case (state_ff)
         ST_REL: begin
            mul_a = $signed({{(MA-GW){1'b0}}, diff});
            mul_b = $signed({{(MB-CW){1'b0}}, cfg.release_coef});
         end
         ST_MUL_L: begin
            mul_a = $signed({{2{left_ff[SW-1]}}, left_ff});
            mul_b = $signed({1'b0, gain_ff});
         end
         ST_MUL_R: begin
            mul_a = $signed({{2{right_ff[SW-1]}}, right_ff});
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      target_in    = target_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      peak_in      = peak_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      prod_in      = mul_a * mul_b;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               left_in  = pop_data[SW-1:0];
               right_in = pop_data[2*SW-1:SW];
               peak_in  = pop_data[3*SW-1:2*SW];
               rem_in   = REM_W'(cfg.ceiling);
               cnt_in   = '0;
               if (pop_data[3*SW]) begin
                  target_in = '0;
                  state_in  = ST_DIV;
               end else begin
                  target_in = slpl_pkg::GAIN_ONE;
                  state_in  = ST_REL;
               end
            end
         end
         ST_DIV: begin
            rem_in    = rem_ge ? rem_sub : rem_shift;
            target_in = {target_ff[GW-2:0], rem_ge};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC - 1)) begin
               state_in = ST_REL;
            end
         end
         ST_REL: begin
            // attack snaps down; otherwise the release product is in flight
            if (target_ff < gain_ff) begin
               gain_in  = target_ff;
               state_in = ST_MUL_L;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            gain_in  = gain_rel;
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            state_in = ST_SAT_L;
         end
         ST_SAT_L: begin
            res_l_in = sat_val;
            if (cfg.stereo_linked) begin
               state_in = ST_MUL_R;
            end else begin
               res_r_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_MUL_R: begin
            state_in = ST_SAT_R;
         end
         ST_SAT_R: begin
            res_r_in = sat_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_l_ff;
               rsp_right_in = res_r_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= slpl_pkg::GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff    <= target_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      peak_ff      <= peak_in;
      res_l_ff     <= res_l_in;
      res_r_ff     <= res_r_in;
      prod_ff      <= prod_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= slpl_pkg::GAIN_ONE)
      else $error("gain above unity");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < peak_ext))
      else $error("divider remainder not below divisor");

   a_mono_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !cfg.stereo_linked) |-> (rsp_right_ff == '0))
      else $error("right output nonzero in mono mode");

endmodule

// ----- rtl/stereo_linked_peak_limiter.sv -----
// ----------------------------------------------------------------------------
// stereo_linked_peak_limiter
// Stereo-linked peak limiter, instant attack and one-pole release.
//
//   channel   handshake               payload
//   req       req_valid / req_stall   req_in_left, req_in_right
//   rsp       rsp_valid / rsp_stall   rsp_out_left, rsp_out_right
//   csr       csr_valid / csr_ready   csr_index, csr_data
//
// Over the ceiling an item first runs the bit-serial divide for ceiling/peak
// in the gain engine; in mono mode the right channel product is skipped.
// Release and both channel products share one multiplier, and a two-entry
// queue lets new pairs in meanwhile. Reset restores the register defaults
// and unity gain. A stalled result holds in the output register; the engine
// waits only when it is full.
// ----------------------------------------------------------------------------
module stereo_linked_peak_limiter #(
   parameter int SAMPLE_WIDTH = slpl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_WIDTH-1:0]           req_in_left,
   input  logic [SAMPLE_WIDTH-1:0]           req_in_right,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]           rsp_out_left,
   output logic [SAMPLE_WIDTH-1:0]           rsp_out_right,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slpl_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int QDW = 3 * SW + 1;

   slpl_pkg::cfg_type cfg_ff, cfg_in;

   logic           queue_full, push, pop, pop_valid;
   logic [QDW-1:0] push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            slpl_pkg::CSR_CEILING: cfg_in.ceiling      = csr_data[slpl_pkg::CEIL_W-1:0];
            slpl_pkg::CSR_RELEASE: cfg_in.release_coef = csr_data[slpl_pkg::COEF_W-1:0];
            slpl_pkg::CSR_LINKED:  cfg_in.stereo_linked = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ceiling       <= slpl_pkg::CEIL_RST;
         cfg_ff.release_coef  <= slpl_pkg::COEF_RST;
         cfg_ff.stereo_linked <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slpl_front #(.SAMPLE_WIDTH(SW)) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_left  (req_in_left),
      .req_in_right (req_in_right),
      .cfg          (cfg_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   slpl_fifo #(.WIDTH(QDW), .DEPTH(slpl_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   slpl_back #(.SAMPLE_WIDTH(SW)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right)
   );

endmodule

// ----- tb/stereo_linked_peak_limiter_tb.sv -----
// ----------------------------------------------------------------------------
// stereo_linked_peak_limiter_tb
// Self-checking bench for the stereo peak limiter. A behavioral limiter in
// the bench tracks the gain and the register values and predicts every
// limited pair. The tests are directed cases for each register and corner,
// then randomized register phases, with bursty input and a receiver that
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module stereo_linked_peak_limiter_tb;

   localparam int SW = slpl_pkg::SAMPLE_WIDTH_DEF;
   localparam int IDX_W  = slpl_pkg::CSR_IDX_W;
   localparam int DATA_W = slpl_pkg::CSR_DATA_W;
   localparam int CEIL_W = slpl_pkg::CEIL_W;
   localparam int COEF_W = slpl_pkg::COEF_W;
   localparam int GAIN_W = slpl_pkg::GAIN_W;
   localparam int FRAC   = slpl_pkg::GAIN_FRAC;
   localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) << (SW - 1));
   localparam logic [SW-1:0] FULL_POS = {1'b0, {(SW - 1){1'b1}}};
   localparam logic [SW-1:0] FULL_NEG = {1'b1, {(SW - 1){1'b0}}};
   localparam logic [SW-1:0] ONE_Q20  = SW'(1048576);
   localparam logic [IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic [SW-1:0] left;
      logic [SW-1:0] right;
   } pair_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [SW-1:0]     req_in_left;
   logic [SW-1:0]     req_in_right;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [SW-1:0]     rsp_out_left;
   logic [SW-1:0]     rsp_out_right;
   logic              csr_valid;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0] csr_data;

   slpl_pkg::cfg_type reg_shadow;
   logic [GAIN_W-1:0] gain_track;
   pair_type          limited_due[$];
   int                error_count = 0;
   int                idle_cycles = 0;
   int                burst_left = 0;
   stall_style_type   stall_style = STALL_NONE;
   int                style_left = 0;

   stereo_linked_peak_limiter #(.SAMPLE_WIDTH(SW)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_left   (req_in_left),
      .req_in_right  (req_in_right),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Limiter behavior
   // ---------------------------------------------------------------------
   function automatic logic [SW-1:0] scale_sample(input longint sample, input longint level);
      longint prod;
      // arithmetic shift floors, which is round-half-up for both signs
      prod = (sample * level + 32768) >>> FRAC;
      if (prod > SAMPLE_MAX) prod = SAMPLE_MAX;
      if (prod < SAMPLE_MIN) prod = SAMPLE_MIN;
      return prod[SW-1:0];
   endfunction

   function automatic pair_type limit_pair(input logic [SW-1:0] left_in,
                                           input logic [SW-1:0] right_in);
      longint   ls, rs, peak, mag_r, target, level;
      pair_type res;
      ls = longint'($signed(left_in));
      rs = longint'($signed(right_in));
      peak  = (ls < 0) ? -ls : ls;
      mag_r = (rs < 0) ? -rs : rs;
      if (reg_shadow.stereo_linked && mag_r > peak) peak = mag_r;
      target = longint'(slpl_pkg::GAIN_ONE);
      if (peak > longint'(reg_shadow.ceiling))
         target = (longint'(reg_shadow.ceiling) << FRAC) / peak;
      level = longint'(gain_track);
      if (target < level) begin
         level = target;
      end else begin
         level = level + (((target - level) * longint'(reg_shadow.release_coef) + 32768)
                          >>> FRAC);
      end
      gain_track = level[GAIN_W-1:0];
      res.left  = scale_sample(ls, level);
      res.right = reg_shadow.stereo_linked ? scale_sample(rs, level) : '0;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Monitors
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         limited_due.push_back(limit_pair(req_in_left, req_in_right));
   end

   task automatic compare_field(input string name, input logic [SW-1:0] want,
                                input logic [SW-1:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d actual %0d",
                  $time, name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pair_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (limited_due.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0d %0d",
                     $time, $signed(rsp_out_left), $signed(rsp_out_right));
            error_count++;
         end else begin
            due = limited_due.pop_front();
            compare_field("out_left", due.left, rsp_out_left);
            compare_field("out_right", due.right, rsp_out_right);
         end
      end
   end

   // receiver stall pattern: switch to a random style when the current run ends
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         style_left  <= $urandom_range(24, 200);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((style_left % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic send_pair(input logic [SW-1:0] left_in, input logic [SW-1:0] right_in);
      int gap;
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_in_left  <= left_in;
      req_in_right <= right_in;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // hold the sender until every outstanding pair has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (limited_due.size() != 0);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] reg_index,
                            input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (reg_index)
         slpl_pkg::CSR_CEILING: reg_shadow.ceiling       = value[CEIL_W-1:0];
         slpl_pkg::CSR_RELEASE: reg_shadow.release_coef  = value[COEF_W-1:0];
         slpl_pkg::CSR_LINKED:  reg_shadow.stereo_linked = value[0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Random picks
   // ---------------------------------------------------------------------
   function automatic logic [SW-1:0] pick_sample();
      logic [SW-1:0] val;
      longint        mag;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            val = SW'($urandom);
            return val;
         end
         3, 4, 5: mag = longint'(reg_shadow.ceiling) + longint'($urandom_range(0, 4096)) - 2048;
         6, 7:    mag = longint'($urandom_range(0, reg_shadow.ceiling));
         8:       mag = longint'($urandom_range(0, 255));
         default: mag = $urandom_range(0, 1) ? SAMPLE_MAX + 1 : SAMPLE_MAX;
      endcase
      if (mag < 0) mag = 0;
      if (mag > SAMPLE_MAX) return FULL_NEG;
      if ($urandom_range(0, 1)) mag = -mag;
      return mag[SW-1:0];
   endfunction

   function automatic logic [CEIL_W-1:0] pick_ceiling();
      logic [CEIL_W-1:0] val;
      case ($urandom_range(0, 5))
         0:       val = '0;
         1:       val = '1;
         2:       val = CEIL_W'($urandom);
         default: val = CEIL_W'($urandom_range(1 << 18, 1 << 21));
      endcase
      return val;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      logic [COEF_W-1:0] val;
      case ($urandom_range(0, 5))
         0:       val = '0;
         1:       val = '1;
         2, 3:    val = COEF_W'($urandom_range(1, 512));
         default: val = COEF_W'($urandom);
      endcase
      return val;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_pair('0, '0);
      send_pair(ONE_Q20 >> 1, -(ONE_Q20 >> 2));
      send_pair(FULL_POS, '0);
      send_pair('0, FULL_NEG);
      send_pair(FULL_NEG, FULL_POS);
      send_pair(SW'(4096), -SW'(4096));
   endtask

   task automatic test_mono_mode();
      wait_drained();
      write_reg(slpl_pkg::CSR_LINKED, '0);
      send_pair(ONE_Q20 >> 1, FULL_POS);
      send_pair(FULL_NEG, FULL_POS);
      send_pair('0, FULL_NEG);
      wait_drained();
      write_reg(slpl_pkg::CSR_LINKED, DATA_W'(1));
   endtask

   task automatic test_zero_ceiling();
      wait_drained();
      write_reg(slpl_pkg::CSR_CEILING, '0);
      send_pair(SW'(1), '0);
      send_pair('0, '0);
      send_pair('0, '1);
   endtask

   task automatic test_release_hold();
      wait_drained();
      write_reg(slpl_pkg::CSR_CEILING, DATA_W'(ONE_Q20));
      write_reg(slpl_pkg::CSR_RELEASE, DATA_W'(1));
      // the gain starts from zero here; each release step rounds up to one
      send_pair(ONE_Q20 + (ONE_Q20 >> 1), '0);
      send_pair('0, '0);
      send_pair(SW'(8192), SW'(100));
      wait_drained();
      write_reg(slpl_pkg::CSR_RELEASE, '1);
      send_pair(SW'(4096), SW'(4096));
      send_pair(-SW'(4096), ONE_Q20);
   endtask

   task automatic test_max_ceiling_and_unmapped();
      logic [DATA_W-1:0] junk;
      junk = DATA_W'($urandom);
      wait_drained();
      write_reg(slpl_pkg::CSR_CEILING, '1);
      send_pair(FULL_NEG, FULL_NEG);
      wait_drained();
      write_reg(CSR_UNMAPPED, junk);
      send_pair(FULL_POS, FULL_NEG);
   endtask

   task automatic test_random_phases();
      logic [DATA_W-1:0] word;
      int                count;
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         write_reg(slpl_pkg::CSR_CEILING, DATA_W'(pick_ceiling()));
         // upper bits of the release and link words are don't-care
         word = DATA_W'($urandom);
         word[COEF_W-1:0] = pick_coef();
         write_reg(slpl_pkg::CSR_RELEASE, word);
         word = DATA_W'($urandom);
         word[0] = ($urandom_range(0, 3) != 0);
         write_reg(slpl_pkg::CSR_LINKED, word);
         count = $urandom_range(45, 65);
         for (int i = 0; i < count; i++) begin
            send_pair(pick_sample(), pick_sample());
            if (phase == 3 && i == count / 2) wait_drained();
         end
      end
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_left  = '0;
      req_in_right = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      reg_shadow.ceiling       = slpl_pkg::CEIL_RST;
      reg_shadow.release_coef  = slpl_pkg::COEF_RST;
      reg_shadow.stereo_linked = 1'b1;
      gain_track   = slpl_pkg::GAIN_ONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mono_mode();
      test_zero_ceiling();
      test_release_hold();
      test_max_ceiling_and_unmapped();
      test_random_phases();

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && limited_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/slpl_pkg.sv
rtl/slpl_fifo.sv
rtl/slpl_front.sv
rtl/slpl_back.sv
rtl/stereo_linked_peak_limiter.sv
tb/stereo_linked_peak_limiter_tb.sv
